// ===== src/assert_macros.svh =====
// Assertion macros shared by the register file ALU executor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/rfae_pkg.sv =====
// Shared types, constants and helper functions for the register file ALU executor.
// No dependencies; compiled first.
`default_nettype none

package rfae_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int NUM_REGS   = 4;
	localparam int REG_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef enum logic [3:0] {
		CMD_LOAD = 4'd0,
		CMD_OUT  = 4'd1,
		CMD_ADD  = 4'd2,
		CMD_SUB  = 4'd3,
		CMD_MUL  = 4'd4,
		CMD_DIV  = 4'd5,
		CMD_MOD  = 4'd6,
		CMD_MOVE = 4'd7,
		CMD_XCHG = 4'd8,
		CMD_AND  = 4'd9,
		CMD_OR   = 4'd10,
		CMD_XOR  = 4'd11
	} cmd_t;

	typedef enum logic [1:0] {
		UD_MUL,
		UD_DIV,
		UD_REM
	} ud_op_t;

	typedef struct packed {
		logic   start;
		ud_op_t op;
	} ud_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ud_rsp_t;

	typedef enum logic [2:0] {
		X_IDLE,
		X_EXEC,
		X_WAIT,
		X_SWAP,
		X_EMIT
	} exec_state_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_ITER,
		U_FIX
	} unit_state_t;

	localparam logic RK_VALUE = 1'b0;
	localparam logic RK_DIV0  = 1'b1;

	// Wrap a 2-bit register field onto the register file.
	function automatic logic [REG_AW-1:0] reg_idx(input logic [1:0] v);
		return REG_AW'(32'(v) % NUM_REGS);
	endfunction

	// Sign-extend or cut a register value to the 32-bit output field.
	function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] v);
		return 32'(signed'(v));
	endfunction

	// Commands that read their operands in two- or three-operand form.
	function automatic logic is_alu_cmd(input cmd_t c);
		logic r;
		case (c)
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
			CMD_AND, CMD_OR, CMD_XOR: r = 1'b1;
			default:                  r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/rfae_ifs.sv =====
// Valid/ready channel interfaces for instruction items and result items.
// No dependencies; compiled after rfae_pkg.
`default_nettype none

interface rfae_instr_if;
	logic              valid;
	logic              ready;
	logic [3:0]        cmd;
	logic [1:0]        dest_reg;
	logic [1:0]        first_src;
	logic [1:0]        second_src;
	logic              three_operand;
	logic signed [31:0] immediate;

	modport source (output valid, cmd, dest_reg, first_src, second_src, three_operand,
		immediate, input ready);
	modport sink (input valid, cmd, dest_reg, first_src, second_src, three_operand,
		immediate, output ready);
endinterface

interface rfae_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_value;
	logic               result_kind;

	modport source (output valid, out_value, result_kind, input ready);
	modport sink (input valid, out_value, result_kind, output ready);
endinterface

`default_nettype wire

// ===== src/rfae_muldiv.sv =====
// Iterative multiply / divide / remainder unit around one shared adder.
// Depends on rfae_pkg; one bit per cycle, then a sign fix step.
`default_nettype none

module rfae_muldiv (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rfae_pkg::ud_req_t            req,
	input  wire logic [rfae_pkg::DATA_WIDTH-1:0] a,
	input  wire logic [rfae_pkg::DATA_WIDTH-1:0] b,
	output rfae_pkg::ud_rsp_t                 rsp,
	output logic [rfae_pkg::DATA_WIDTH-1:0]   result
);
	import rfae_pkg::*;

	localparam int W = DATA_WIDTH;

	unit_state_t       state_q, state_d;
	ud_op_t            op_q;
	logic [W:0]        acc_q;
	logic [W-1:0]      opa_q;
	logic [W-1:0]      opb_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [W-1:0]      result_q;

	logic [W:0]        add_x;
	logic [W:0]        add_y;
	logic              add_sub;
	logic [W+1:0]      sum;
	logic [W:0]        rem_sh;
	logic              ge;
	logic [W-1:0]      fix_val;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	// Shared adder: accumulate for multiply, trial subtract for divide and remainder, negate at the end.
	always_comb begin
		rem_sh  = {acc_q[W-1:0], opa_q[W-1]};
		fix_val = (op_q == UD_DIV) ? opa_q : acc_q[W-1:0];
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			U_ITER: begin
				if (op_q == UD_MUL) begin
					add_x = {1'b0, acc_q[W-1:0]};
					add_y = {1'b0, opa_q};
				end else begin
					add_x   = rem_sh;
					add_y   = {1'b0, opb_q};
					add_sub = 1'b1;
				end
			end
			U_FIX: begin
				add_y   = {1'b0, fix_val};
				add_sub = 1'b1;
			end
			default: ;
		endcase
		sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(W+2){add_sub}}) + (W+2)'(add_sub);
		ge  = !sum[W+1];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE:  if (req.start) state_d = U_ITER;
			U_ITER:  if (cnt_q == CNT_W'(W - 1)) state_d = U_FIX;
			U_FIX:   state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_comb begin
		rsp.idle = (state_q == U_IDLE);
		rsp.done = done_q;
		result   = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == U_FIX);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					cnt_q <= '0;
					acc_q <= '0;
					if (req.op == UD_MUL) begin
						opa_q <= a;
						opb_q <= b;
						neg_q <= 1'b0;
					end else begin
						opa_q <= mag(a);
						opb_q <= mag(b);
						neg_q <= (req.op == UD_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
					end
				end
			end
			U_ITER: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (op_q == UD_MUL) begin
					if (opb_q[0]) acc_q <= {1'b0, sum[W-1:0]};
					opa_q <= {opa_q[W-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[W-1:1]};
				end else begin
					acc_q <= ge ? sum[W:0] : rem_sh;
					opa_q <= {opa_q[W-2:0], ge};
				end
			end
			U_FIX: begin
				result_q <= neg_q ? sum[W-1:0] : fix_val;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/register_file_alu_executor.sv =====
// Top level: register file, instruction sequencer and result register.
// Depends on rfae_pkg, rfae_ifs, rfae_muldiv and assert_macros.svh.
//
// Usage:
//   instr  - valid/ready sink of decoded instructions (cmd, register indexes,
//            operand form, immediate). An item is taken when valid and ready
//            are high at a rising edge; ready is high only while idle.
//   result - valid/ready source of result items. Only the out command and a
//            divide or remainder by zero produce one.
//   Load, move, add, sub and the logic commands pass from the execute state
//   straight back to idle; exchange adds a swap state, and out and a divide
//   by zero add an emit state that waits while the result side stalls.
//   Multiply, divide and remainder wait for the shared bit-serial unit.
//   A result item becomes valid as its instruction leaves the emit state.
//   Reset clears all registers to zero at once (per-entry valid bits) and
//   empties the result register. When the receiver stalls, a held result
//   stays put; the block keeps taking instructions and holds its input at
//   the next one that has a result to deliver, until the held item leaves.
`default_nettype none
`include "assert_macros.svh"

module register_file_alu_executor (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rfae_instr_if.sink    instr,
	rfae_result_if.source result
);
	import rfae_pkg::*;

	localparam int W = DATA_WIDTH;

	exec_state_t       state_q, state_d;

	logic [W-1:0]      mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [W-1:0]      rd_a_q;
	logic [W-1:0]      rd_b_q;

	cmd_t              cmd_q;
	logic [REG_AW-1:0] d_q;
	logic [REG_AW-1:0] s1_q;
	logic signed [31:0] imm_q;

	logic [31:0]       pend_value_q;
	logic              pend_kind_q;
	logic              out_valid_q;
	logic [31:0]       out_value_q;
	logic              out_kind_q;

	logic              accept;
	cmd_t              cmd_c;
	logic              alu3_c;
	logic [REG_AW-1:0] ra_c;
	logic [REG_AW-1:0] rb_c;
	logic              we;
	logic [REG_AW-1:0] wa;
	logic [W-1:0]      wd;
	logic              emit_go;
	logic              div0;

	ud_req_t           ud_req;
	ud_rsp_t           ud_rsp;
	logic [W-1:0]      ud_result;

	rfae_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ud_req),
		.a      (rd_a_q),
		.b      (rd_b_q),
		.rsp    (ud_rsp),
		.result (ud_result)
	);

	always_comb begin
		accept  = instr.valid && instr.ready;
		cmd_c   = cmd_t'(instr.cmd);
		alu3_c  = is_alu_cmd(cmd_c) && instr.three_operand;
		ra_c    = alu3_c ? reg_idx(instr.first_src) : reg_idx(instr.dest_reg);
		rb_c    = alu3_c ? reg_idx(instr.second_src) : reg_idx(instr.first_src);
		emit_go = !out_valid_q || result.ready;
		div0    = (rd_b_q == '0);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			X_IDLE: if (accept) state_d = X_EXEC;
			X_EXEC: begin
				case (cmd_q)
					CMD_OUT:          state_d = X_EMIT;
					CMD_MUL:          state_d = X_WAIT;
					CMD_DIV, CMD_MOD: state_d = div0 ? X_EMIT : X_WAIT;
					CMD_XCHG:         state_d = X_SWAP;
					default:          state_d = X_IDLE;
				endcase
			end
			X_WAIT:  if (ud_rsp.done) state_d = X_IDLE;
			X_SWAP:  state_d = X_IDLE;
			X_EMIT:  if (emit_go) state_d = X_IDLE;
			default: state_d = X_IDLE;
		endcase
	end

	always_comb begin
		instr.ready    = (state_q == X_IDLE);
		result.valid   = out_valid_q;
		result.out_value   = out_value_q;
		result.result_kind = out_kind_q;
		we           = 1'b0;
		wa           = d_q;
		wd           = rd_b_q;
		ud_req.start = 1'b0;
		case (cmd_q)
			CMD_MUL: ud_req.op = UD_MUL;
			CMD_DIV: ud_req.op = UD_DIV;
			default: ud_req.op = UD_REM;
		endcase
		case (state_q)
			X_EXEC: begin
				we = 1'b1;
				case (cmd_q)
					CMD_LOAD: wd = W'(imm_q);
					CMD_ADD:  wd = rd_a_q + rd_b_q;
					CMD_SUB:  wd = rd_a_q - rd_b_q;
					CMD_AND:  wd = rd_a_q & rd_b_q;
					CMD_OR:   wd = rd_a_q | rd_b_q;
					CMD_XOR:  wd = rd_a_q ^ rd_b_q;
					CMD_MOVE, CMD_XCHG: wd = rd_b_q;
					CMD_MUL: begin
						we           = 1'b0;
						ud_req.start = 1'b1;
					end
					CMD_DIV, CMD_MOD: begin
						we           = 1'b0;
						ud_req.start = !div0;
					end
					default: we = 1'b0;
				endcase
			end
			X_WAIT: begin
				we = ud_rsp.done;
				wd = ud_result;
			end
			X_SWAP: begin
				we = 1'b1;
				wa = s1_q;
				wd = rd_a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= X_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) vld_q[wa] <= 1'b1;
			if (state_q == X_EMIT && emit_go) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// Register file: one write port, two registered read ports; unwritten entries read zero.
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (accept) begin
			rd_a_q <= vld_q[ra_c] ? mem[ra_c] : '0;
			rd_b_q <= vld_q[rb_c] ? mem[rb_c] : '0;
			cmd_q  <= cmd_c;
			d_q    <= reg_idx(instr.dest_reg);
			s1_q   <= reg_idx(instr.first_src);
			imm_q  <= instr.immediate;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == X_EXEC) begin
			if (cmd_q == CMD_OUT) begin
				pend_value_q <= to_out(rd_a_q);
				pend_kind_q  <= RK_VALUE;
			end else begin
				pend_value_q <= '0;
				pend_kind_q  <= RK_DIV0;
			end
		end
		if (state_q == X_EMIT && emit_go) begin
			out_value_q <= pend_value_q;
			out_kind_q  <= pend_kind_q;
		end
	end

	`ASSERT_IMP(a_start_idle, clk, arst_n, ud_req.start, ud_rsp.idle)
	`ASSERT_IMP(a_done_in_wait, clk, arst_n, ud_rsp.done, state_q == X_WAIT)
	`ASSERT_NXT(a_xchg_swap, clk, arst_n, state_q == X_EXEC && cmd_q == CMD_XCHG,
		state_q == X_SWAP)
	`ASSERT_NXT(a_emit_loads, clk, arst_n, state_q == X_EMIT && emit_go, out_valid_q)

endmodule

`default_nettype wire

// ===== verif/register_file_alu_executor_checker.sv =====
`timescale 1ns / 1ps
// Checker for register_file_alu_executor: watches both channels, tracks its own copy of
// the register file and compares every result item with the oldest predicted read-out.
// Depends on rfae_pkg and the channel interfaces in rfae_ifs.

module register_file_alu_executor_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rfae_instr_if     instr,
	rfae_result_if    result,
	output int        mismatch_count,
	output int        readouts_left
);
	import rfae_pkg::*;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [31:0] value;
		logic        kind;
	} readout_t;

	word_t    shadow_regs [NUM_REGS];
	readout_t readouts [$];

	function automatic void execute_instruction(input logic [3:0] code,
		input logic [1:0] dest_f, input logic [1:0] src1_f, input logic [1:0] src2_f,
		input logic three, input logic [31:0] imm);
		int    d, s1, s2;
		word_t a, b, r, ua, ub, held;
		d  = int'(dest_f) % NUM_REGS;
		s1 = int'(src1_f) % NUM_REGS;
		s2 = int'(src2_f) % NUM_REGS;
		case (code)
			CMD_LOAD: begin
				shadow_regs[d] = word_t'(signed'(imm));
				return;
			end
			CMD_OUT: begin
				readouts.push_back(readout_t'{32'(signed'(shadow_regs[d])), RK_VALUE});
				return;
			end
			CMD_MOVE: begin
				shadow_regs[d] = shadow_regs[s1];
				return;
			end
			CMD_XCHG: begin
				held            = shadow_regs[d];
				shadow_regs[d]  = shadow_regs[s1];
				shadow_regs[s1] = held;
				return;
			end
			default: ;
		endcase
		// unused codes leave everything alone
		if (code > CMD_XOR)
			return;
		a = three ? shadow_regs[s1] : shadow_regs[d];
		b = three ? shadow_regs[s2] : shadow_regs[s1];
		case (code)
			CMD_ADD: r = a + b;
			CMD_SUB: r = a - b;
			CMD_MUL: r = a * b;
			CMD_DIV, CMD_MOD: begin
				if (b == '0) begin
					readouts.push_back(readout_t'{32'd0, RK_DIV0});
					return;
				end
				ua = a[DATA_WIDTH-1] ? -a : a;
				ub = b[DATA_WIDTH-1] ? -b : b;
				// work on magnitudes, then restore the sign: truncation toward zero
				if (code == CMD_DIV) begin
					r = ua / ub;
					if (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1])
						r = -r;
				end else begin
					r = ua % ub;
					if (a[DATA_WIDTH-1])
						r = -r;
				end
			end
			CMD_AND: r = a & b;
			CMD_OR:  r = a | b;
			default: r = a ^ b;
		endcase
		shadow_regs[d] = r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		readout_t got, want;
		if (!arst_n) begin
			foreach (shadow_regs[i])
				shadow_regs[i] = '0;
			readouts.delete();
			mismatch_count = 0;
		end else begin
			if (instr.valid && instr.ready)
				execute_instruction(instr.cmd, instr.dest_reg, instr.first_src,
					instr.second_src, instr.three_operand, instr.immediate);
			if (result.valid && result.ready) begin
				got = readout_t'{result.out_value, result.result_kind};
				if (readouts.size() == 0) begin
					mismatch_count++;
					$display("%0t: result item with none expected: out_value %h result_kind %b",
						$time, got.value, got.kind);
				end else begin
					want = readouts.pop_front();
					if (got.value !== want.value) begin
						mismatch_count++;
						$display("%0t: out_value expected %h actual %h",
							$time, want.value, got.value);
					end
					if (got.kind !== want.kind) begin
						mismatch_count++;
						$display("%0t: result_kind expected %b actual %b",
							$time, want.kind, got.kind);
					end
				end
			end
		end
		readouts_left = readouts.size();
	end

endmodule

// ===== verif/register_file_alu_executor_test.sv =====
`timescale 1ns / 1ps
// Testbench top for register_file_alu_executor: drives instruction items, throttles the
// result channel and gives the verdict. Depends on rfae_pkg, rfae_ifs, the block and
// register_file_alu_executor_checker.

module register_file_alu_executor_test;
	import rfae_pkg::*;

	typedef struct {
		logic [3:0]  code;
		logic [1:0]  dest;
		logic [1:0]  src1;
		logic [1:0]  src2;
		logic        three;
		logic [31:0] imm;
	} instr_item_t;

	logic clk = 1'b0;
	logic arst_n;

	int mismatch_count;
	int readouts_left;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_len;
	int hold_seq;
	int hold_seen;

	rfae_instr_if  instr_ch ();
	rfae_result_if result_ch ();

	register_file_alu_executor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	register_file_alu_executor_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.instr          (instr_ch),
		.result         (result_ch),
		.mismatch_count (mismatch_count),
		.readouts_left  (readouts_left)
	);

	always #4 clk = ~clk;

	function automatic instr_item_t make_item(input logic [3:0] code, input int d,
		input int s1, input int s2, input int th, input logic [31:0] imm);
		instr_item_t it;
		it.code  = code;
		it.dest  = 2'(d);
		it.src1  = 2'(s1);
		it.src2  = 2'(s2);
		it.three = 1'(th);
		it.imm   = imm;
		return it;
	endfunction

	function automatic instr_item_t random_item();
		instr_item_t it;
		int          pick;
		it = make_item(CMD_OUT, $urandom_range(3), $urandom_range(3), $urandom_range(3),
			$urandom_range(1), $urandom);
		// bias immediates toward small values and extremes so division gets exercised
		case ($urandom_range(3))
			0: it.imm = $urandom;
			1: it.imm = 32'($urandom_range(8)) - 32'd4;
			2: it.imm = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: it.imm = $urandom >> $urandom_range(31);
		endcase
		pick = $urandom_range(99);
		if (pick < 18)
			it.code = CMD_LOAD;
		else if (pick < 36)
			it.code = CMD_OUT;
		else if (pick < 41)
			it.code = CMD_MOVE;
		else if (pick < 46)
			it.code = CMD_XCHG;
		else if (pick < 97) begin
			case ($urandom_range(7))
				0: it.code = CMD_ADD;
				1: it.code = CMD_SUB;
				2: it.code = CMD_MUL;
				3: it.code = CMD_DIV;
				4: it.code = CMD_MOD;
				5: it.code = CMD_AND;
				6: it.code = CMD_OR;
				default: it.code = CMD_XOR;
			endcase
		end else
			it.code = 4'(CMD_XOR) + 4'($urandom_range(1, 4));
		return it;
	endfunction

	// Call at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input instr_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			instr_ch.valid = 1'b0;
			@(negedge clk);
		end
		instr_ch.cmd           = it.code;
		instr_ch.dest_reg      = it.dest;
		instr_ch.first_src     = it.src1;
		instr_ch.second_src    = it.src2;
		instr_ch.three_operand = it.three;
		instr_ch.immediate     = it.imm;
		instr_ch.valid         = 1'b1;
		@(posedge clk);
		while (!instr_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		instr_ch.valid = 1'b0;
		wait (readouts_left == 0);
		@(negedge clk);
	endtask

	// Result side: random stalls, plus a long hold whenever one is requested.
	initial begin
		result_ch.ready = 1'b0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen       = hold_seq;
				result_ch.ready = 1'b0;
				repeat (hold_len - 1)
					@(negedge clk);
			end else
				result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		instr_ch.valid         = 1'b0;
		instr_ch.cmd           = CMD_LOAD;
		instr_ch.dest_reg      = '0;
		instr_ch.first_src     = '0;
		instr_ch.second_src    = '0;
		instr_ch.three_operand = 1'b0;
		instr_ch.immediate     = '0;
		send_idle_pct          = 26;
		recv_idle_pct          = 56;
		hold_len               = 0;
		hold_seq               = 0;
		arst_n                 = 1'b0;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, minimum over minus one, zero divisors, every command
		send_item(make_item(CMD_LOAD, 0, 0, 0, 0, 32'h7fff_ffff));
		send_item(make_item(CMD_LOAD, 1, 2, 1, 1, 32'h8000_0000));
		send_item(make_item(CMD_LOAD, 2, 3, 2, 1, 32'hffff_ffff));
		send_item(make_item(CMD_DIV, 3, 1, 2, 1, 32'h0));
		send_item(make_item(CMD_OUT, 3, 2, 1, 1, 32'hffff_ffff));
		send_item(make_item(CMD_MOD, 3, 1, 2, 1, 32'h0));
		send_item(make_item(CMD_OUT, 3, 0, 0, 0, 32'h0));
		send_item(make_item(CMD_DIV, 0, 3, 0, 0, 32'h0));
		send_item(make_item(CMD_MOD, 1, 0, 3, 1, 32'h0));
		send_item(make_item(CMD_ADD, 0, 0, 0, 0, 32'h0));
		send_item(make_item(CMD_SUB, 3, 1, 0, 1, 32'h0));
		send_item(make_item(CMD_MUL, 3, 0, 1, 1, 32'h0));
		send_item(make_item(CMD_AND, 2, 1, 3, 0, 32'h0));
		send_item(make_item(CMD_OR, 3, 1, 0, 1, 32'h0));
		send_item(make_item(CMD_XOR, 0, 2, 1, 0, 32'h0));
		send_item(make_item(CMD_MOVE, 3, 0, 2, 1, 32'h0));
		send_item(make_item(CMD_XCHG, 0, 1, 3, 1, 32'h0));
		send_item(make_item(CMD_XCHG, 2, 2, 0, 0, 32'h0));
		for (int k = 1; k <= 4; k++)
			send_item(make_item(4'(CMD_XOR) + 4'(k), k - 1, k % 4, 3, k % 2, $urandom));
		for (int r = 0; r < 4; r++)
			send_item(make_item(CMD_OUT, r, 3 - r, r, r % 2, 32'h0));
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 342; n++) begin
				// hold off the result side while read-outs keep coming: fill and stall
				if (phase == 0 && n == 100) begin
					hold_len = 400;
					hold_seq++;
					repeat (24)
						send_item(make_item(CMD_OUT, $urandom_range(3), $urandom_range(3),
							$urandom_range(3), $urandom_range(1), $urandom));
				end
				send_item(random_item());
			end
			drain_results();
		end

		repeat (48)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule
